// ===== hdl/bb3_pkg.sv =====
`default_nettype none
package bb3_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int MIN_WIDTH = 3;
  localparam int LINE_AW   = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 24;

  // Output queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register reset values
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Register indexes (byte address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Reciprocal of 9 in 16-bit fixed point, exact floor for sums up to 9*255
  localparam logic [12:0] RECIP9 = 13'd7282;

  typedef logic [LINE_AW-1:0] col_t;
  typedef logic [LINE_AW:0]   wuse_t;
  typedef logic [11:0]        row_t;
  typedef logic [10:0]        fw_t;
  typedef logic [11:0]        fh_t;
  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [QUEUE_AW-1:0] qptr_t;
  typedef logic [QUEUE_AW:0]   qcount_t;

  // One column of the window, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } wcol_t;

  // Per-channel sums of one column (3 x 255 max)
  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } csum_t;

  // Per-channel sums of the window (9 x 255 max)
  typedef struct packed {
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
  } wsum_t;

  // One result item in the output queue
  typedef struct packed {
    logic [31:0] word;
    logic        eor;
    logic        eof;
    logic        last;
  } res_t;

  function automatic csum_t col_sum(input wcol_t col);
    csum_t s;
    s.r = 10'(col.top[23:16]) + 10'(col.mid[23:16]) + 10'(col.bot[23:16]);
    s.g = 10'(col.top[15:8])  + 10'(col.mid[15:8])  + 10'(col.bot[15:8]);
    s.b = 10'(col.top[7:0])   + 10'(col.mid[7:0])   + 10'(col.bot[7:0]);
    return s;
  endfunction

  // floor(x / 9) by reciprocal multiply
  function automatic logic [7:0] div9(input logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(RECIP9);
    return prod[23:16];
  endfunction

  function automatic logic [31:0] pack_blur(input wsum_t s);
    return {div9(s.r), div9(s.g), div9(s.b), 8'h00};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bb3_ram.sv =====
`default_nettype none
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/box_blur_3x3_rgba.sv =====
// Channel   Dir   Handshake                       Payload
// in        in    in_valid / in_stall             mode, pixel_word
// out       out   out_valid / out_stall           blurred_word, end_of_row,
//                                                 end_of_frame, last_of_run
// cfg       in    psel/penable/pwrite/pready      paddr, pwdata, prdata
//
// One item per cycle while in_stall is low; each item passes the line-store read stage,
// the window/sum stage and the divide stage, then enters an 8-entry queue.
// in_stall rises while the output queue holds more than 6 results.
// Reset clears counters, window, pipeline and queue; line stores are not
// cleared (an entry is read only after its row was written).
`default_nettype none
module box_blur_3x3_rgba (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [31:0] pixel_word,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      blurred_word,
  output logic             end_of_row,
  output logic             end_of_frame,
  output logic             last_of_run,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- registers ----------------
  bb3_pkg::fw_t frame_width;
  bb3_pkg::fh_t frame_height;
  logic         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::fw_t'(bb3_pkg::WIDTH_RESET);
      frame_height <= bb3_pkg::fh_t'(bb3_pkg::HEIGHT_RESET);
    end else if (cfg_write) begin
      unique case (paddr[2])
        bb3_pkg::REG_WIDTH:  frame_width  <= pwdata[10:0];
        bb3_pkg::REG_HEIGHT: frame_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bb3_pkg::REG_WIDTH:  prdata = {21'b0, frame_width};
      bb3_pkg::REG_HEIGHT: prdata = {20'b0, frame_height};
      default:             prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  bb3_pkg::qcount_t q_count;
  logic             en;
  logic             accept;

  // Advance when the queue can take two more results
  assign en       = q_count <= bb3_pkg::qcount_t'(bb3_pkg::QUEUE_DEPTH - 2);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // ---------------- stage 0: position and line store read ----------------
  bb3_pkg::col_t  column_count;
  bb3_pkg::row_t  row_count;
  bb3_pkg::wuse_t width_use;
  bb3_pkg::col_t  wlast;
  bb3_pkg::col_t  col_sel;
  logic           last_col;
  logic           flush_row;

  always_comb begin
    if (frame_width < bb3_pkg::fw_t'(bb3_pkg::MIN_WIDTH)) begin
      width_use = bb3_pkg::wuse_t'(bb3_pkg::MIN_WIDTH);
    end else if (32'(frame_width) > 32'(bb3_pkg::MAX_WIDTH)) begin
      width_use = bb3_pkg::wuse_t'(bb3_pkg::MAX_WIDTH);
    end else begin
      width_use = bb3_pkg::wuse_t'(frame_width);
    end
    wlast = bb3_pkg::col_t'(width_use - bb3_pkg::wuse_t'(1));
    // a counter left beyond the row ends it
    col_sel   = (column_count > wlast) ? wlast : column_count;
    last_col  = col_sel == wlast;
    flush_row = row_count >= frame_height;
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= flush_row ? '0 : row_count + bb3_pkg::row_t'(1);
      end else begin
        column_count <= col_sel + bb3_pkg::col_t'(1);
      end
    end
  end

  // ---------------- stage 1: window update and sums ----------------
  logic          v1;
  bb3_pkg::pix_t pix1;
  bb3_pkg::col_t c1;
  logic          has_above1;
  logic          has_above2_1;
  logic          last1;
  logic          flush1;
  logic          emit1;

  bb3_pkg::pix_t rd_a;
  bb3_pkg::pix_t rd_b;
  logic          ram_we;

  assign ram_we = en && v1;

  // line_store_a holds the previous row, line_store_b the row before that
  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) line_store_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c1),
    .wdata (pix1),
    .re    (accept),
    .raddr (col_sel),
    .rdata (rd_a)
  );

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) line_store_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c1),
    .wdata (rd_a),
    .re    (accept),
    .raddr (col_sel),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix1         <= (mode == bb3_pkg::MODE_FLUSH || flush_row) ? '0 : pixel_word[31:8];
      c1           <= col_sel;
      has_above1   <= row_count != '0;
      has_above2_1 <= row_count > bb3_pkg::row_t'(1);
      last1        <= last_col;
      flush1       <= flush_row;
      emit1        <= (row_count != '0) && (col_sel != '0);
    end
  end

  // Window columns, left to right
  bb3_pkg::wcol_t win1;
  bb3_pkg::wcol_t win2;
  bb3_pkg::wcol_t win0_next;
  bb3_pkg::wcol_t win1_next;
  bb3_pkg::wcol_t win2_next;
  bb3_pkg::csum_t cs0;
  bb3_pkg::csum_t cs1;
  bb3_pkg::csum_t cs2;
  bb3_pkg::wsum_t tail_sum_next;
  bb3_pkg::wsum_t main_sum_next;

  always_comb begin
    // a new row starts with empty left columns
    if (c1 == '0) begin
      win0_next = '0;
      win1_next = '0;
    end else begin
      win0_next = win1;
      win1_next = win2;
    end
    win2_next.top = has_above2_1 ? rd_b : '0;
    win2_next.mid = has_above1 ? rd_a : '0;
    win2_next.bot = pix1;

    cs0 = bb3_pkg::col_sum(win0_next);
    cs1 = bb3_pkg::col_sum(win1_next);
    cs2 = bb3_pkg::col_sum(win2_next);

    // tail window drops the left column and pads zero on the right
    tail_sum_next.r = 12'(cs1.r) + 12'(cs2.r);
    tail_sum_next.g = 12'(cs1.g) + 12'(cs2.g);
    tail_sum_next.b = 12'(cs1.b) + 12'(cs2.b);
    main_sum_next.r = tail_sum_next.r + 12'(cs0.r);
    main_sum_next.g = tail_sum_next.g + 12'(cs0.g);
    main_sum_next.b = tail_sum_next.b + 12'(cs0.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win1 <= '0;
      win2 <= '0;
    end else if (en && v1) begin
      win1 <= win1_next;
      win2 <= win2_next;
    end
  end

  // ---------------- stage 2: divide and queue ----------------
  logic           v2;
  logic           emit2;
  logic           last2;
  logic           flush2;
  bb3_pkg::wsum_t main_sum;
  bb3_pkg::wsum_t tail_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit2    <= emit1;
      last2    <= last1;
      flush2   <= flush1;
      main_sum <= main_sum_next;
      tail_sum <= tail_sum_next;
    end
  end

  bb3_pkg::res_t main_res;
  bb3_pkg::res_t tail_res;
  logic          push_main;
  logic          push_tail;

  always_comb begin
    main_res.word = bb3_pkg::pack_blur(main_sum);
    main_res.eor  = 1'b0;
    main_res.eof  = 1'b0;
    main_res.last = !last2;
    tail_res.word = bb3_pkg::pack_blur(tail_sum);
    tail_res.eor  = 1'b1;
    tail_res.eof  = flush2;
    tail_res.last = 1'b1;
    push_main     = en && v2 && emit2;
    push_tail     = push_main && last2;
  end

  // Output queue
  bb3_pkg::res_t    queue [0:bb3_pkg::QUEUE_DEPTH-1];
  bb3_pkg::qptr_t   wr_ptr;
  bb3_pkg::qptr_t   rd_ptr;
  bb3_pkg::qptr_t   wr_ptr_inc;
  bb3_pkg::qcount_t push_count;
  logic             pop;
  bb3_pkg::res_t    head;

  assign wr_ptr_inc = wr_ptr + bb3_pkg::qptr_t'(1);
  assign push_count = bb3_pkg::qcount_t'(push_main) + bb3_pkg::qcount_t'(push_tail);
  assign out_valid  = q_count != '0;
  assign pop        = out_valid && !out_stall;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_main) begin
      queue[wr_ptr] <= main_res;
    end
    if (push_tail) begin
      queue[wr_ptr_inc] <= tail_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + bb3_pkg::qptr_t'(push_count);
      rd_ptr  <= rd_ptr + bb3_pkg::qptr_t'(pop);
      q_count <= q_count + push_count - bb3_pkg::qcount_t'(pop);
    end
  end

  assign blurred_word = head.word;
  assign end_of_row   = head.eor;
  assign end_of_frame = head.eof;
  assign last_of_run  = head.last;

`ifndef ASSERT_OFF
  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= bb3_pkg::qcount_t'(bb3_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

  // a line store write never hits the entry read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (v1 && en && accept) |-> (col_sel != c1))
    else $error("line store read/write clash");

  // no result enters the queue while the pipeline is held
  a_hold_no_push: assert property (@(posedge clk) disable iff (rst)
    !en |=> (q_count <= $past(q_count)))
    else $error("queue grew while stalled");

  // frame end only on the row-end tail result
  a_eof_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> (end_of_row && last_of_run))
    else $error("end_of_frame without row end");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int LIMIT       = 500000;
  localparam int SETTLE      = 16;
  localparam int DRAIN       = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 800;

  // hand-picked items: {mode, pixel_word}
  // 0..8 width 3 height 2, 9..14 width 0 height 1, 15..17 width 2 height 0
  localparam logic [32:0] DIRECTED [18] = '{
    {bb3_pkg::MODE_PIXEL, 32'hFFFFFFFF}, {bb3_pkg::MODE_PIXEL, 32'hFFFFFFFF},
    {bb3_pkg::MODE_PIXEL, 32'hFFFFFFFF}, {bb3_pkg::MODE_PIXEL, 32'hFFFFFFFF},
    {bb3_pkg::MODE_FLUSH, 32'hFFFFFFFF}, {bb3_pkg::MODE_PIXEL, 32'h00000000},
    {bb3_pkg::MODE_PIXEL, 32'hFFFFFFFF}, {bb3_pkg::MODE_FLUSH, 32'h00000000},
    {bb3_pkg::MODE_FLUSH, 32'hFFFFFFFF}, {bb3_pkg::MODE_PIXEL, 32'h00FF00FF},
    {bb3_pkg::MODE_PIXEL, 32'hFF00FF00}, {bb3_pkg::MODE_PIXEL, 32'h80808080},
    {bb3_pkg::MODE_FLUSH, 32'h00000000}, {bb3_pkg::MODE_FLUSH, 32'h7F7F7F7F},
    {bb3_pkg::MODE_FLUSH, 32'h00000000}, {bb3_pkg::MODE_PIXEL, 32'hFFFFFFFF},
    {bb3_pkg::MODE_FLUSH, 32'h00000000}, {bb3_pkg::MODE_PIXEL, 32'h12345678}
  };

  typedef enum {STALL_NONE, STALL_COIN, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  // Blur predictor plus store of expected blurred pixels
  class blur_check_t;
    bit [23:0]       prev_row  [bb3_pkg::MAX_WIDTH];
    bit [23:0]       prev_row2 [bb3_pkg::MAX_WIDTH];
    bit [23:0]       win [9];
    int unsigned     col_pos;
    bit [11:0]       row_pos;
    bit [10:0]       width_reg;
    bit [11:0]       height_reg;
    bb3_pkg::res_t   expected_px [$];
    int              errors;

    function new();
      width_reg  = 11'(bb3_pkg::WIDTH_RESET);
      height_reg = 12'(bb3_pkg::HEIGHT_RESET);
      col_pos = 0;
      row_pos = '0;
      errors = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == bb3_pkg::REG_WIDTH) width_reg = val[10:0];
      else height_reg = val[11:0];
    endfunction

    // width register clamped to the supported range
    function int unsigned width_used();
      int unsigned w;
      w = width_reg;
      if (w < bb3_pkg::MIN_WIDTH) w = bb3_pkg::MIN_WIDTH;
      if (w > bb3_pkg::MAX_WIDTH) w = bb3_pkg::MAX_WIDTH;
      return w;
    endfunction

    function bit at_frame_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    function int pending();
      return expected_px.size();
    endfunction

    // floor of the per-channel 3x3 mean, packed R,G,B,0
    function logic [31:0] window_mean(bit [23:0] w [9]);
      int unsigned r, g, b;
      r = 0; g = 0; b = 0;
      foreach (w[i]) begin
        r += w[i][23:16];
        g += w[i][15:8];
        b += w[i][7:0];
      end
      return {8'(r / 9), 8'(g / 9), 8'(b / 9), 8'h00};
    endfunction

    // advance the window by one accepted item, queue the blurred pixels it yields
    function void take_pixel(logic m, logic [31:0] word);
      int unsigned wd, c;
      bit flush_row, last_col;
      bit [23:0] px, up1, up2;
      bit [23:0] tail [9];
      bb3_pkg::res_t r;
      wd = width_used();
      flush_row = row_pos >= height_reg;
      c = col_pos;
      if (c >= wd) c = wd - 1;
      last_col = c >= wd - 1;
      px  = (m == bb3_pkg::MODE_FLUSH || flush_row) ? 24'h0 : word[31:8];
      up1 = (row_pos >= 1) ? prev_row[c] : 24'h0;
      up2 = (row_pos >= 2) ? prev_row2[c] : 24'h0;
      prev_row2[c] = prev_row[c];
      prev_row[c]  = px;

      // shift window left, new column on the right
      if (c == 0) begin
        foreach (win[i]) win[i] = '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          win[i*3]   = win[i*3+1];
          win[i*3+1] = win[i*3+2];
        end
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = px;

      if (row_pos >= 1 && c >= 1) begin
        r.word = window_mean(win);
        r.eor  = 1'b0;
        r.eof  = 1'b0;
        r.last = !last_col;
        expected_px.push_back(r);
        // right edge pixel: right column is outside the frame
        if (last_col) begin
          for (int i = 0; i < 3; i++) begin
            tail[i*3]   = win[i*3+1];
            tail[i*3+1] = win[i*3+2];
            tail[i*3+2] = '0;
          end
          r.word = window_mean(tail);
          r.eor  = 1'b1;
          r.eof  = flush_row;
          r.last = 1'b1;
          expected_px.push_back(r);
        end
      end

      if (last_col) begin
        col_pos = 0;
        row_pos = flush_row ? 12'd0 : row_pos + 12'd1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_blurred(bb3_pkg::res_t got);
      bb3_pkg::res_t exp_px;
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: word %h eor %b eof %b last %b",
                   got.word, got.eor, got.eof, got.last);
        return;
      end
      exp_px = expected_px.pop_front();
      if (got.word !== exp_px.word || got.eor !== exp_px.eor ||
          got.eof !== exp_px.eof || got.last !== exp_px.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h eor %b eof %b last %b / got %h eor %b eof %b last %b",
                   exp_px.word, exp_px.eor, exp_px.eof, exp_px.last,
                   got.word, got.eor, got.eof, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = bb3_pkg::MODE_PIXEL;
  logic [31:0] pixel_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] blurred_word;
  logic        end_of_row;
  logic        end_of_frame;
  logic        last_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  blur_check_t   sb = new();
  bb3_pkg::res_t seen_px;
  int            cycles = 0;
  int            hold_asked = 0;
  int            burst_left = 0;
  int            gap_max = 0;

  box_blur_3x3_rgba dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .pixel_word(pixel_word),
    .out_valid(out_valid), .out_stall(out_stall), .blurred_word(blurred_word),
    .end_of_row(end_of_row), .end_of_frame(end_of_frame), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // outputs are stable at the falling edge; a taken result is checked there
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_px.word = blurred_word;
      seen_px.eor  = end_of_row;
      seen_px.eof  = end_of_frame;
      seen_px.last = last_of_run;
      sb.check_blurred(seen_px);
    end
  end

  // result side stall: random runs of patterns, long hold on request
  initial begin : receiver
    stall_mode_t smode;
    int run_left, hold_left, holds_seen;
    smode = STALL_NONE;
    run_left = 0;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_asked) begin
        holds_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          smode = stall_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(20, 200);
        end
        run_left--;
        case (smode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFFFFFF;
      1:       return 32'h00000000;
      default: return $urandom();
    endcase
  endfunction

  // offer one item in bursts with random gaps; returns at the accepting edge
  task automatic push_item(input logic m, input logic [31:0] w);
    int gap;
    bit taken;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) gap = $urandom_range(0, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    pixel_word <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!in_stall) begin
        sb.take_pixel(m, w);
        taken = 1'b1;
      end
      @(posedge clk);
    end
  endtask

  // setup then access phase, then psel and penable drop
  task automatic write_reg(input logic idx, input logic [31:0] val);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait for every expected pixel, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // full frame plus flush row, with occasional swapped mode
  task automatic send_frame(input int w, input int h);
    int unsigned wd;
    logic m;
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, w);
    write_reg(bb3_pkg::REG_HEIGHT, h);
    wd = sb.width_used();
    for (int r = 0; r <= h; r++) begin
      for (int c = 0; c < wd; c++) begin
        m = (r == h) ? bb3_pkg::MODE_FLUSH : bb3_pkg::MODE_PIXEL;
        if ($urandom_range(0, 15) == 0) begin
          m = (m == bb3_pkg::MODE_PIXEL) ? bb3_pkg::MODE_FLUSH : bb3_pkg::MODE_PIXEL;
        end
        push_item(m, rand_pixel());
      end
    end
  endtask

  initial begin : stimulus
    int w, h, random_items;
    random_items = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: min width, height 1 and 0, mode swaps, saturated channels
    write_reg(bb3_pkg::REG_WIDTH, 3);
    write_reg(bb3_pkg::REG_HEIGHT, 2);
    for (int i = 0; i < 9; i++) push_item(DIRECTED[i][32], DIRECTED[i][31:0]);
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, 0);
    write_reg(bb3_pkg::REG_HEIGHT, 1);
    for (int i = 9; i < 15; i++) push_item(DIRECTED[i][32], DIRECTED[i][31:0]);
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, 2);
    write_reg(bb3_pkg::REG_HEIGHT, 0);
    for (int i = 15; i < 18; i++) push_item(DIRECTED[i][32], DIRECTED[i][31:0]);

    // height cut below the current row mid-frame: row turns into the flush row
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, 8);
    write_reg(bb3_pkg::REG_HEIGHT, 12'hFFF);
    for (int i = 0; i < 28; i++) push_item(bb3_pkg::MODE_PIXEL, rand_pixel());
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, 5);
    write_reg(bb3_pkg::REG_HEIGHT, 2);
    while (!sb.at_frame_start()) push_item(bb3_pkg::MODE_PIXEL, rand_pixel());

    // width cut mid-row: column past the new end closes the row
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, 8);
    write_reg(bb3_pkg::REG_HEIGHT, 6);
    for (int i = 0; i < 22; i++) push_item(bb3_pkg::MODE_PIXEL, rand_pixel());
    wait_idle();
    write_reg(bb3_pkg::REG_WIDTH, 4);
    while (!sb.at_frame_start()) push_item(bb3_pkg::MODE_PIXEL, rand_pixel());

    // wide frame, back to back, with the result side held off
    gap_max = 0;
    hold_asked++;
    send_frame(40, 3);

    // random frames, mostly small
    while (random_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(13, 48);
        default: w = $urandom_range(3, 12);
      endcase
      h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0, 1:    gap_max = 0;
        2:       gap_max = 2;
        default: gap_max = 6;
      endcase
      if ($urandom_range(0, 9) == 0) hold_asked++;
      send_frame(w, h);
      if (h != 0) random_items += (h + 1) * sb.width_used();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bb3_pkg.sv
hdl/bb3_ram.sv
hdl/box_blur_3x3_rgba.sv
verif/tb_top.sv
